@@ sv/frag_pkg.sv @@
// frag_pkg: shared types, constants and the payload-send function of the message fragmenter.
// Depends on nothing; imported by every frag_* module and by message_fragmenter_core.
package frag_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int Q_DEPTH     = 4;
	localparam int QPTR_W      = $clog2(Q_DEPTH);
	localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] INFO_HEADER = 8'h80;

	localparam logic REG_VERSION   = 1'b0;
	localparam logic REG_PRIO_MASK = 1'b1;

	typedef struct packed {
		logic [7:0]  msg_byte;
		logic        first_of_message;
		logic [15:0] message_length;
		logic [5:0]  priority_req;
		logic        is_data;
		logic [7:0]  message_header;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_start;
		logic       frame_end;
		logic       message_end;
		logic       frame_is_data;
		logic [5:0] frame_priority;
		logic       run_last;
	} out_item_t;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_INFO,
		PH_PKG,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic       vld;
		logic       hdr;
		logic [7:0] len_byte;
		logic [7:0] pkg;
		logic [7:0] data;
		logic       fe;
		logic       me;
	} slot_t;

	typedef struct packed {
		slot_t      s0;
		slot_t      s1;
		logic [5:0] prio;
		logic       dflag;
	} entry_t;

	typedef struct packed {
		slot_t       slot;
		logic [16:0] ml;
		logic [7:0]  fl;
	} send_res_t;

	function automatic send_res_t frag_send(logic [16:0] ml, logic [7:0] fl, logic [7:0] b,
			logic [5:0] ver, logic [5:0] prio, logic dflag);
		send_res_t  r;
		logic       last;
		logic [7:0] len;
		logic [7:0] fl_n;
		last = (ml <= 17'(MAX_PAYLOAD));
		len  = last ? ml[7:0] : 8'(MAX_PAYLOAD);
		fl_n = (fl == 8'd0) ? len : fl;
		r.ml = ml - 17'd1;
		r.fl = fl_n - 8'd1;
		r.slot.vld      = 1'b1;
		r.slot.hdr      = (fl == 8'd0);
		r.slot.len_byte = len + 8'd2;
		r.slot.pkg      = {last, dflag, ver | prio};
		r.slot.data     = b;
		r.slot.fe       = (r.fl == 8'd0);
		r.slot.me       = (r.ml == 17'd0);
		return r;
	endfunction

endpackage

@@ sv/message_fragmenter_core.sv @@
// message_fragmenter_core: top level with the configuration registers, front, queue and back.
// Depends on frag_pkg, frag_front, frag_queue and frag_back.
//
// Cuts each message, led by its message-header byte, into frames of at most MAX_PAYLOAD
// payload bytes and sends them one byte beat per cycle while out_stall is low: length,
// info header 0x80, package header, then payload. The input side takes one beat per cycle
// while the four-entry queue between front and back has room; an input beat yields zero to
// five output beats (up to eight with MAX_PAYLOAD of 1), so the sustained rate is set
// by the back end, and input stalls appear at frame starts. Registers: version_field at
// address 0, the priority mask at address 4; write them only while the block is idle.
module message_fragmenter_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  frag_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output frag_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import frag_pkg::*;

	logic [5:0] version_q;
	logic [5:0] pmask_q;
	logic       q_full;
	logic       push;
	entry_t     push_entry;
	logic       pop;
	logic       head_vld;
	entry_t     head;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_PRIO_MASK) ? {26'd0, pmask_q} : {26'd0, version_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= 6'd0;
			pmask_q   <= 6'd7;
		end else if (wr_en) begin
			if (paddr[2] == REG_VERSION) begin
				version_q <= pwdata[5:0];
			end else begin
				pmask_q <= pwdata[5:0];
			end
		end
	end

	frag_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.version    (version_q),
		.pmask      (pmask_q),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	frag_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_vld   (head_vld),
		.head       (head)
	);

	frag_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (head_vld),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ sv/frag_front.sv @@
// frag_front: accepts input beats, tracks message and frame counts, and turns each
// in-message beat into a queue entry of up to two payload slots. Depends on frag_pkg.
module frag_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  frag_pkg::in_item_t in_data,
	input  logic [5:0]        version,
	input  logic [5:0]        pmask,
	input  logic              q_full,
	output logic              push,
	output frag_pkg::entry_t  push_entry
);
	import frag_pkg::*;

	logic [16:0] ml_q;
	logic [7:0]  fl_q;
	logic        in_msg_q;
	logic [5:0]  prio_q;
	logic        dflag_q;

	logic        accept;
	logic [5:0]  prio_n;
	logic        dflag_n;
	send_res_t   r0;
	send_res_t   r1;
	logic [16:0] ml_n;
	logic [7:0]  fl_n;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		prio_n  = in_data.first_of_message ? (in_data.priority_req & pmask) : prio_q;
		dflag_n = in_data.first_of_message ? in_data.is_data : dflag_q;
		if (in_data.first_of_message) begin
			r0 = frag_send({1'b0, in_data.message_length} + 17'd1, 8'd0,
				in_data.message_header, version, prio_n, dflag_n);
		end else begin
			r0 = frag_send(ml_q, fl_q, in_data.msg_byte, version, prio_n, dflag_n);
		end
		r1 = frag_send(r0.ml, r0.fl, in_data.msg_byte, version, prio_n, dflag_n);
		if (in_data.first_of_message && in_data.message_length != 16'd0) begin
			ml_n = r1.ml;
			fl_n = r1.fl;
			push_entry.s1 = r1.slot;
		end else begin
			ml_n = r0.ml;
			fl_n = r0.fl;
			push_entry.s1 = '0;
		end
		push_entry.s0    = r0.slot;
		push_entry.prio  = prio_n;
		push_entry.dflag = dflag_n;
		push = accept && (in_data.first_of_message || in_msg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ml_q     <= '0;
			fl_q     <= '0;
			in_msg_q <= 1'b0;
			prio_q   <= '0;
			dflag_q  <= 1'b0;
		end else if (push) begin
			ml_q     <= ml_n;
			fl_q     <= fl_n;
			in_msg_q <= (ml_n != 17'd0);
			prio_q   <= prio_n;
			dflag_q  <= dflag_n;
		end
	end

endmodule

@@ sv/frag_queue.sv @@
// frag_queue: short FIFO of classified entries between the front and the back.
// Depends on frag_pkg.
module frag_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  frag_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_vld,
	output frag_pkg::entry_t head
);
	import frag_pkg::*;

	entry_t            mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(Q_DEPTH));
	assign head_vld = (cnt_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ sv/frag_back.sv @@
// frag_back: walks each queue entry and emits frame beats (length, info, package header,
// payload) through an output register. Depends on frag_pkg.
module frag_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_vld,
	input  frag_pkg::entry_t   head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output frag_pkg::out_item_t out_data
);
	import frag_pkg::*;

	entry_t    cur_q;
	logic      cur_vld_q;
	logic      sel_q;
	phase_t    phase_q;
	out_item_t out_q;
	logic      out_vld_q;

	phase_t    phase_n;
	logic      sel_n;
	logic      adv;
	logic      fire;
	logic      done;
	slot_t     slot;
	out_item_t beat;

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_comb begin
		adv  = !out_vld_q || !out_stall;
		fire = adv && cur_vld_q;
		slot = sel_q ? cur_q.s1 : cur_q.s0;
		done = (phase_q == PH_DATA) && (sel_q || !cur_q.s1.vld);
		pop  = head_vld && (!cur_vld_q || (fire && done));

		beat.frame_start    = (phase_q == PH_LEN);
		beat.frame_end      = (phase_q == PH_DATA) && slot.fe;
		beat.message_end    = (phase_q == PH_DATA) && slot.me;
		beat.frame_is_data  = cur_q.dflag;
		beat.frame_priority = cur_q.prio;
		beat.run_last       = done;
		case (phase_q)
			PH_LEN:  beat.frame_byte = slot.len_byte;
			PH_INFO: beat.frame_byte = INFO_HEADER;
			PH_PKG:  beat.frame_byte = slot.pkg;
			PH_DATA: beat.frame_byte = slot.data;
			default: beat.frame_byte = slot.data;
		endcase

		phase_n = phase_q;
		sel_n   = sel_q;
		if (pop) begin
			sel_n   = 1'b0;
			phase_n = head.s0.hdr ? PH_LEN : PH_DATA;
		end else if (fire) begin
			case (phase_q)
				PH_LEN:  phase_n = PH_INFO;
				PH_INFO: phase_n = PH_PKG;
				PH_PKG:  phase_n = PH_DATA;
				PH_DATA: begin
					sel_n   = 1'b1;
					phase_n = cur_q.s1.hdr ? PH_LEN : PH_DATA;
				end
				default: phase_n = PH_DATA;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			sel_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			sel_q   <= sel_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_vld_q <= 1'b1;
			end else if (fire && done) begin
				cur_vld_q <= 1'b0;
			end
			if (adv) begin
				out_vld_q <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (fire) begin
			out_q <= beat;
		end
	end

endmodule

@@ sv/frag_checker.sv @@
// frag_checker: port-level checks on the output beats of message_fragmenter_core.
// Depends on frag_pkg; bound to the top level at the end of this file.
module frag_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input frag_pkg::out_item_t out_data
);
	import frag_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output beat changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_start |->
			out_data.frame_byte >= 8'd3 && out_data.frame_byte <= 8'(MAX_PAYLOAD + 2))
		else $error("frame length byte out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.message_end |-> out_data.frame_end && out_data.run_last)
		else $error("message end without frame end and run end");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_start |-> !out_data.frame_end && !out_data.run_last)
		else $error("length beat flagged as frame or run end");

endmodule

bind message_fragmenter_core frag_checker u_frag_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

@@ tb/message_fragmenter_core_test.sv @@
// message_fragmenter_core_test: self-checking bench for message_fragmenter_core.
// Sends message beats and APB register writes, predicts every frame byte and checks each output beat.
// Depends on frag_pkg and message_fragmenter_core.
module message_fragmenter_core_test;
	import frag_pkg::*;

	localparam int unsigned LIMIT_CYCLES  = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned RANDOM_ITEMS  = 290;
	localparam int unsigned MAX_REPORTS   = 40;
	localparam logic [7:0]  LAST_FRAG     = 8'h80;
	localparam logic [7:0]  DATA_MSG      = 8'h40;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	int unsigned cycle_count    = 0;
	int unsigned mismatch_count = 0;
	int unsigned stall_left     = 0;
	logic        src_pace       = 1'b0;
	logic        sink_hold      = 1'b0;

	logic [16:0] msg_bytes_left   = '0;
	logic [7:0]  frame_bytes_left = '0;
	logic        msg_open         = 1'b0;
	logic [5:0]  latched_prio     = '0;
	logic        latched_data     = 1'b0;
	logic [5:0]  cur_version      = 6'd0;
	logic [5:0]  cur_prio_mask    = 6'd7;
	out_item_t   frame_bytes_due[$];

	message_fragmenter_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("message_fragmenter_core verification failed");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left <= stall_left - 1;
		else if (sink_hold && $urandom_range(1) == 1) begin
			out_stall  <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			out_stall  <= 1'b0;
			stall_left <= $urandom_range(4);
		end
	end

	task automatic report_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("cycle %0d: mismatch: %s", cycle_count, what);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
	endtask

	always @(posedge clk) begin : check_beat
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frame_bytes_due.size() == 0)
				report_mismatch($sformatf("unexpected beat, byte %02h", out_data.frame_byte));
			else begin
				want = frame_bytes_due.pop_front();
				check_field("frame_byte", out_data.frame_byte, want.frame_byte);
				check_field("frame_start", out_data.frame_start, want.frame_start);
				check_field("frame_end", out_data.frame_end, want.frame_end);
				check_field("message_end", out_data.message_end, want.message_end);
				check_field("frame_is_data", out_data.frame_is_data, want.frame_is_data);
				check_field("frame_priority", out_data.frame_priority, want.frame_priority);
				check_field("run_last", out_data.run_last, want.run_last);
			end
		end
	end

	function automatic void push_frame_byte(logic [7:0] b, logic fs, logic fe, logic me);
		out_item_t r;
		r.frame_byte     = b;
		r.frame_start    = fs;
		r.frame_end      = fe;
		r.message_end    = me;
		r.frame_is_data  = latched_data;
		r.frame_priority = latched_prio;
		r.run_last       = 1'b0;
		frame_bytes_due.push_back(r);
	endfunction

	function automatic void add_payload(logic [7:0] b);
		logic       last;
		logic [7:0] len;
		if (msg_bytes_left == '0)
			return;
		if (frame_bytes_left == '0) begin
			last = (msg_bytes_left <= 17'(MAX_PAYLOAD));
			len  = last ? msg_bytes_left[7:0] : 8'(MAX_PAYLOAD);
			frame_bytes_left = len;
			push_frame_byte(8'(len + 8'd2), 1'b1, 1'b0, 1'b0);
			push_frame_byte(INFO_HEADER, 1'b0, 1'b0, 1'b0);
			push_frame_byte((last ? LAST_FRAG : 8'h00) | (latched_data ? DATA_MSG : 8'h00)
				| {2'b00, cur_version | latched_prio}, 1'b0, 1'b0, 1'b0);
		end
		frame_bytes_left = frame_bytes_left - 8'd1;
		msg_bytes_left   = msg_bytes_left - 17'd1;
		push_frame_byte(b, 1'b0, frame_bytes_left == '0, msg_bytes_left == '0);
		if (msg_bytes_left == '0)
			msg_open = 1'b0;
	endfunction

	function automatic void predict_frames(in_item_t it);
		int unsigned before_n;
		out_item_t   tail;
		before_n = frame_bytes_due.size();
		if (it.first_of_message) begin
			latched_prio     = it.priority_req & cur_prio_mask;
			latched_data     = it.is_data;
			msg_bytes_left   = {1'b0, it.message_length} + 17'd1;
			frame_bytes_left = '0;
			msg_open         = 1'b1;
			add_payload(it.message_header);
			if (it.message_length != 16'd0)
				add_payload(it.msg_byte);
		end else if (msg_open)
			add_payload(it.msg_byte);
		if (frame_bytes_due.size() > before_n) begin
			tail = frame_bytes_due.pop_back();
			tail.run_last = 1'b1;
			frame_bytes_due.push_back(tail);
		end
	endfunction

	function automatic in_item_t random_item();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic in_item_t body_item();
		in_item_t it;
		it = random_item();
		it.first_of_message = 1'b0;
		return it;
	endfunction

	function automatic int unsigned msg_items(int unsigned len);
		return (len == 0) ? 1 : len;
	endfunction

	function automatic int unsigned pick_length();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			case ($urandom_range(4))
				0: return 31;
				1: return 32;
				2: return 33;
				3: return 63;
				default: return 64;
			endcase
		end
		if (roll < 80)
			return $urandom_range(24);
		return $urandom_range(120, 25);
	endfunction

	function automatic logic [5:0] pick_reg_value();
		int unsigned roll;
		roll = $urandom_range(3);
		if (roll == 0)
			return 6'd0;
		if (roll == 1)
			return 6'h3F;
		return 6'($urandom());
	endfunction

	task automatic send_beat(in_item_t it);
		int unsigned gap;
		gap = src_pace ? pick_gap() : 0;
		predict_frames(it);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_message(in_item_t head, int unsigned items);
		head.first_of_message = 1'b1;
		send_beat(head);
		repeat (items - 1) send_beat(body_item());
	endtask

	task automatic drain_quiet();
		in_valid <= 1'b0;
		while (frame_bytes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic reg_idx, logic [5:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_idx, 2'b00};
		pwdata  <= {26'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (reg_idx == REG_VERSION)
			cur_version = value;
		else
			cur_prio_mask = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[5:0] !== value)
			report_mismatch($sformatf("register %0d read %02h want %02h", reg_idx,
				prdata[5:0], value));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed_cases();
		in_item_t it;
		src_pace  = 1'b0;
		sink_hold = 1'b0;
		// drop: nothing open yet
		it = '1;
		it.first_of_message = 1'b0;
		send_beat(it);
		it = '1;
		it.message_length = 16'd0;
		it.msg_byte = 8'hAA;
		send_message(it, 1);
		it = '0;
		it.message_length = 16'd1;
		send_message(it, 1);
		src_pace  = 1'b1;
		sink_hold = 1'b1;
		it = '0;
		it.message_length = 16'd2;
		it.msg_byte       = 8'hFF;
		it.priority_req   = 6'h2A;
		it.is_data        = 1'b1;
		it.message_header = 8'h55;
		send_message(it, 2);
		// abandon a maximum-length message with a fresh one
		it = random_item();
		it.message_length = 16'hFFFF;
		send_message(it, 4);
		it = random_item();
		it.message_length = 16'd3;
		send_message(it, 3);
		send_beat(body_item());
		drain_quiet();
	endtask

	task automatic test_mid_message_update();
		in_item_t it;
		src_pace  = 1'b1;
		sink_hold = 1'b1;
		set_reg(REG_VERSION, 6'h15);
		set_reg(REG_PRIO_MASK, 6'h3F);
		it = random_item();
		it.message_length = 16'd45;
		it.priority_req   = 6'h2A;
		send_message(it, 20);
		drain_quiet();
		// hold the open message across a register update
		set_reg(REG_VERSION, 6'h2A);
		set_reg(REG_PRIO_MASK, 6'h00);
		repeat (25) send_beat(body_item());
		drain_quiet();
	endtask

	task automatic test_register_settings();
		in_item_t    it;
		int unsigned k;
		int unsigned len;
		logic [5:0]  ver;
		logic [5:0]  mask;
		for (k = 0; k < 5; k++) begin
			case (k)
				0: begin ver = 6'h00; mask = 6'h00; end
				1: begin ver = 6'h3F; mask = 6'h3F; end
				2: begin ver = 6'h0F; mask = 6'h3C; end
				3: begin ver = 6'h30; mask = 6'h03; end
				default: begin ver = 6'h2A; mask = 6'h15; end
			endcase
			src_pace  = (k != 1);
			sink_hold = (k != 2);
			set_reg(REG_VERSION, ver);
			set_reg(REG_PRIO_MASK, mask);
			repeat (2) begin
				len = $urandom_range(24);
				it = random_item();
				it.message_length = 16'(len);
				send_message(it, msg_items(len));
			end
			drain_quiet();
		end
	endtask

	task automatic test_random_traffic();
		in_item_t    it;
		int unsigned sent;
		int unsigned roll;
		int unsigned len;
		int unsigned items;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(7) == 0) begin
				drain_quiet();
				set_reg(REG_VERSION, pick_reg_value());
				set_reg(REG_PRIO_MASK, pick_reg_value());
			end
			roll = $urandom_range(9);
			src_pace  = (roll != 0);
			sink_hold = (roll != 1);
			roll = $urandom_range(99);
			it = random_item();
			if (roll < 6 && !msg_open)
				repeat ($urandom_range(3, 1)) send_beat(body_item());
			else if (roll < 12) begin
				len = $urandom_range(65535);
				items = $urandom_range(12, 1);
				if (items > msg_items(len))
					items = msg_items(len);
				it.message_length = 16'(len);
				send_message(it, items);
				sent += items;
			end else if (roll < 22) begin
				len = pick_length();
				items = $urandom_range(msg_items(len), 1);
				it.message_length = 16'(len);
				send_message(it, items);
				sent += items;
			end else begin
				len = pick_length();
				it.message_length = 16'(len);
				send_message(it, msg_items(len));
				sent += msg_items(len);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_mid_message_update();
		test_register_settings();
		test_random_traffic();
		drain_quiet();
		if (mismatch_count == 0)
			$display("message_fragmenter_core verification clean");
		else
			$display("message_fragmenter_core verification failed");
		$finish;
	end

endmodule
